/* rtl/prht_pkg.sv */
// ---------------------------------------------------------------------------
// prht_pkg
// shared types and codes for the priority rectangle hit test
// ---------------------------------------------------------------------------
package prht_pkg;

  // item command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // configuration register indexes, paddr[3:2]
  localparam logic [1:0] REG_LAYER_ENABLED = 2'd0;
  localparam logic [1:0] REG_REGION_COUNT  = 2'd1;
  localparam logic [1:0] REG_MAP_WIDTH     = 2'd2;
  localparam logic [1:0] REG_MAP_HEIGHT    = 2'd3;

  // fixed field widths
  localparam int unsigned PRIO_W  = 16;
  localparam int unsigned POINT_W = 13;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned MAP_W   = 13;

  // scan sequencer
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_FLUSH = 4'b1000
  } prht_state_e;

endpackage

/* rtl/priority_rectangle_hit_test.sv */
// a write transfer updates the table at its accepting edge and gives no result
// a query reads entries 0 to limit - 1, one table read per cycle, limit = min(region_count, slots)
// one write per cycle while idle; after a query no item is taken until its result is loaded
// a query that misses on the layer or the map bounds, or meets a zero limit, skips the scan
// and goes straight to flush; reset clears named flags, config, sequencer, out valid
// ---------------------------------------------------------------------------
// priority_rectangle_hit_test
// region table in a synchronous memory, scanned one entry per cycle for the
// highest priority rectangle that contains the query point
// ---------------------------------------------------------------------------
module priority_rectangle_hit_test #(
  parameter int unsigned REGION_SLOTS = 16,
  parameter int unsigned COORD_BITS   = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // apb configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  // item channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                command_i,
  input  logic [3:0]          entry_index_i,
  input  logic signed [12:0]  point_x_i,
  input  logic signed [12:0]  point_y_i,
  input  logic [11:0]         rect_x_i,
  input  logic [11:0]         rect_y_i,
  input  logic [12:0]         rect_width_i,
  input  logic [12:0]         rect_height_i,
  input  logic signed [15:0]  priority_req_i,
  input  logic                named_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                hit_o,
  output logic [3:0]          region_index_o,
  output logic signed [15:0]  hit_priority_o
);

  // widths that follow from the table geometry
  localparam int unsigned IDX_W = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
  localparam int unsigned LIM_W = $clog2(REGION_SLOTS + 1);
  localparam int unsigned CNT_W = (LIM_W > prht_pkg::COUNT_W) ? LIM_W : prht_pkg::COUNT_W;
  localparam int unsigned ORG_W = COORD_BITS;
  localparam int unsigned EXT_W = COORD_BITS + 1;
  localparam int unsigned ENT_W = prht_pkg::PRIO_W + 2 * EXT_W + 2 * ORG_W;

  // -------------------------------------------------------------------------
  // configuration registers
  // -------------------------------------------------------------------------
  logic                          layer_enabled_q;
  logic [prht_pkg::COUNT_W-1:0]  region_count_q;
  logic [prht_pkg::MAP_W-1:0]    map_width_q;
  logic [prht_pkg::MAP_W-1:0]    map_height_q;
  logic                          cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layer_enabled_q <= 1'b0;
      region_count_q  <= '0;
      map_width_q     <= '0;
      map_height_q    <= '0;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        prht_pkg::REG_LAYER_ENABLED: layer_enabled_q <= pwdata[0];
        prht_pkg::REG_REGION_COUNT:  region_count_q  <= pwdata[prht_pkg::COUNT_W-1:0];
        prht_pkg::REG_MAP_WIDTH:     map_width_q     <= pwdata[prht_pkg::MAP_W-1:0];
        prht_pkg::REG_MAP_HEIGHT:    map_height_q    <= pwdata[prht_pkg::MAP_W-1:0];
        default: ;
      endcase
    end
  end

  // read back, zero extended
  always_comb begin
    unique case (paddr[3:2])
      prht_pkg::REG_LAYER_ENABLED: prdata = 32'(layer_enabled_q);
      prht_pkg::REG_REGION_COUNT:  prdata = 32'(region_count_q);
      prht_pkg::REG_MAP_WIDTH:     prdata = 32'(map_width_q);
      prht_pkg::REG_MAP_HEIGHT:    prdata = 32'(map_height_q);
      default:                     prdata = '0;
    endcase
  end

  // -------------------------------------------------------------------------
  // item acceptance and decode
  // -------------------------------------------------------------------------
  prht_pkg::prht_state_e state_q, state_d;

  logic in_accept;
  logic is_write;
  logic is_query;

  assign in_stall_o = (state_q != prht_pkg::ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign is_write   = in_accept && (command_i == prht_pkg::CMD_WRITE);
  assign is_query   = in_accept && (command_i == prht_pkg::CMD_QUERY);

  // number of entries searched, clamped to the table depth
  logic [CNT_W-1:0] count_ext;
  logic [CNT_W-1:0] slots_c;
  logic [CNT_W-1:0] limit;
  logic [CNT_W-1:0] last_idx;

  assign count_ext = CNT_W'(region_count_q);
  assign slots_c   = CNT_W'(REGION_SLOTS);
  assign limit     = (count_ext < slots_c) ? count_ext : slots_c;
  assign last_idx  = limit - CNT_W'(1);

  // early miss: layer off, negative point, or point at or beyond the map edge
  logic in_bounds;

  assign in_bounds = layer_enabled_q
                  && !point_x_i[12] && !point_y_i[12]
                  && ({1'b0, point_x_i[11:0]} < map_width_q)
                  && ({1'b0, point_y_i[11:0]} < map_height_q);

  // write address, slots past the table depth are dropped
  logic [8:0]       wr_idx_w;
  logic [IDX_W-1:0] wr_addr;
  logic             wr_en;

  assign wr_idx_w = 9'(entry_index_i);
  assign wr_addr  = wr_idx_w[IDX_W-1:0];
  assign wr_en    = is_write && (wr_idx_w < 9'(REGION_SLOTS));

  // packed entry: rank, height, width, top, left
  logic [ENT_W-1:0] wr_entry;
  logic [15:0]      rx16;
  logic [15:0]      ry16;
  logic [16:0]      rw17;
  logic [16:0]      rh17;

  assign rx16     = 16'(rect_x_i);
  assign ry16     = 16'(rect_y_i);
  assign rw17     = 17'(rect_width_i);
  assign rh17     = 17'(rect_height_i);
  assign wr_entry = {priority_req_i, rh17[EXT_W-1:0], rw17[EXT_W-1:0],
                     ry16[ORG_W-1:0], rx16[ORG_W-1:0]};

  // -------------------------------------------------------------------------
  // region table: one write port, one registered read port
  // named flags sit in flip-flops so that reset can clear them at once
  // -------------------------------------------------------------------------
  logic [ENT_W-1:0]        region_mem [REGION_SLOTS];
  logic [REGION_SLOTS-1:0] named_q;
  logic [IDX_W-1:0]        scan_q, scan_d;
  logic [ENT_W-1:0]        rd_entry_q;
  logic                    rd_named_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      region_mem[wr_addr] <= wr_entry;
    end
    rd_entry_q <= region_mem[scan_q];
    rd_named_q <= named_q[scan_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      named_q <= '0;
    end else if (wr_en) begin
      named_q[wr_addr] <= named_i;
    end
  end

  // -------------------------------------------------------------------------
  // scan sequencer
  // idle -> scan (one read issued per cycle) -> drain (last compare)
  //      -> flush (hand the best entry to the result register); an early miss goes idle -> flush
  // -------------------------------------------------------------------------
  logic scan_last;
  logic rd_vld_q;
  logic [IDX_W-1:0] rd_idx_q;
  logic out_load;

  assign scan_last = (CNT_W'(scan_q) == last_idx);
  assign out_load  = (state_q == prht_pkg::ST_FLUSH) && (!out_valid_o || !out_stall_i);

  always_comb begin
    state_d = state_q;
    scan_d  = scan_q;
    unique case (state_q)
      prht_pkg::ST_IDLE: begin
        scan_d = '0;
        if (is_query) begin
          if (in_bounds && (limit != '0)) begin
            state_d = prht_pkg::ST_SCAN;
          end else begin
            state_d = prht_pkg::ST_FLUSH;
          end
        end
      end
      prht_pkg::ST_SCAN: begin
        if (scan_last) begin
          state_d = prht_pkg::ST_DRAIN;
        end else begin
          scan_d = scan_q + IDX_W'(1);
        end
      end
      prht_pkg::ST_DRAIN: state_d = prht_pkg::ST_FLUSH;
      prht_pkg::ST_FLUSH: begin
        if (out_load) begin
          state_d = prht_pkg::ST_IDLE;
        end
      end
      default: state_d = prht_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= prht_pkg::ST_IDLE;
      scan_q   <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      scan_q   <= scan_d;
      rd_vld_q <= (state_q == prht_pkg::ST_SCAN);
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= scan_q;
  end

  // -------------------------------------------------------------------------
  // compare stage on the entry read in the previous cycle
  // -------------------------------------------------------------------------
  logic [12:0]        px_q;
  logic [12:0]        py_q;
  logic [ORG_W-1:0]   ent_rx;
  logic [ORG_W-1:0]   ent_ry;
  logic [EXT_W-1:0]   ent_rw;
  logic [EXT_W-1:0]   ent_rh;
  logic signed [15:0] ent_pri;
  logic [17:0]        px18;
  logic [17:0]        py18;
  logic [17:0]        x_lo;
  logic [17:0]        y_lo;
  logic [17:0]        x_hi;
  logic [17:0]        y_hi;
  logic               ent_hit;
  logic               take;

  assign {ent_pri, ent_rh, ent_rw, ent_ry, ent_rx} = rd_entry_q;

  assign px18 = 18'(px_q);
  assign py18 = 18'(py_q);
  assign x_lo = 18'(ent_rx);
  assign y_lo = 18'(ent_ry);
  assign x_hi = x_lo + 18'(ent_rw);
  assign y_hi = y_lo + 18'(ent_rh);

  // half-open containment; empty or unnamed entries never hit
  assign ent_hit = rd_named_q && (ent_rw != '0) && (ent_rh != '0)
                && (px18 >= x_lo) && (px18 < x_hi)
                && (py18 >= y_lo) && (py18 < y_hi);

  logic               found_q;
  logic [IDX_W-1:0]   best_idx_q;
  logic signed [15:0] best_pri_q;

  // entries come in ascending order, so >= hands ties to the later index
  assign take = rd_vld_q && ent_hit && (!found_q || (ent_pri >= best_pri_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (is_query) begin
      found_q <= 1'b0;
    end else if (take) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_query) begin
      px_q <= point_x_i;
      py_q <= point_y_i;
    end
    if (take) begin
      best_idx_q <= rd_idx_q;
      best_pri_q <= ent_pri;
    end
  end

  // -------------------------------------------------------------------------
  // result register, parts the scan from the downstream stall
  // -------------------------------------------------------------------------
  logic               out_valid_q;
  logic               hit_q;
  logic [3:0]         region_index_q;
  logic signed [15:0] hit_priority_q;
  logic [8:0]         best_idx_w;

  assign best_idx_w = 9'(best_idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      hit_q          <= found_q;
      region_index_q <= found_q ? best_idx_w[3:0] : 4'd0;
      hit_priority_q <= found_q ? best_pri_q : 16'sd0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hit_o          = hit_q;
  assign region_index_o = region_index_q;
  assign hit_priority_o = hit_priority_q;

  // -------------------------------------------------------------------------
  // assertions
  // -------------------------------------------------------------------------
  a_miss_is_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> (region_index_o == 4'd0) && (hit_priority_o == 16'sd0))
    else $error("miss result carries a nonzero index or priority");

  a_read_follows_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> $past(state_q == prht_pkg::ST_SCAN))
    else $error("compare stage active without a read issued");

  a_drain_has_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == prht_pkg::ST_DRAIN |-> rd_vld_q)
    else $error("drain cycle without the last entry in the compare stage");

  a_query_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_query |=> (state_q == prht_pkg::ST_SCAN) || (state_q == prht_pkg::ST_FLUSH))
    else $error("accepted query did not start the sequencer");

endmodule

/* dv/tb_priority_rectangle_hit_test.sv */
// ---------------------------------------------------------------------------
// tb_priority_rectangle_hit_test
// self-checking bench: region table writes and point queries go in over the
// valid/stall item channel, a local region table scores each query without a typed-in answer,
// and each result transfer is compared field by field with the oldest owed answer
// ---------------------------------------------------------------------------
module tb_priority_rectangle_hit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS        = 16;
  localparam int LIMIT_CYCLES = 400000;
  localparam int SETTLE       = 24;   // longer than a full scan of sixteen slots
  localparam int PHASE_ITEMS  = 80;
  localparam int PHASES       = 9;
  localparam int MAX_REPORTS  = 10;

  // one item on the input channel, with an optional typed-in answer
  typedef struct {
    logic               cmd;
    logic [3:0]         slot;
    logic signed [12:0] px;
    logic signed [12:0] py;
    logic [11:0]        rx;
    logic [11:0]        ry;
    logic [12:0]        rw;
    logic [12:0]        rh;
    logic signed [15:0] pri;
    logic               nm;
    bit                 typed;
    logic               t_hit;
    logic [3:0]         t_idx;
    logic signed [15:0] t_pri;
  } stim_t;

  typedef struct {
    logic               hit;
    logic [3:0]         idx;
    logic signed [15:0] pri;
  } hit_result_t;

  bit                 clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [3:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               command_i;
  logic [3:0]         entry_index_i;
  logic signed [12:0] point_x_i;
  logic signed [12:0] point_y_i;
  logic [11:0]        rect_x_i;
  logic [11:0]        rect_y_i;
  logic [12:0]        rect_width_i;
  logic [12:0]        rect_height_i;
  logic signed [15:0] priority_req_i;
  logic               named_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic               hit_o;
  logic [3:0]         region_index_o;
  logic signed [15:0] hit_priority_o;

  priority_rectangle_hit_test u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .entry_index_i  (entry_index_i),
    .point_x_i      (point_x_i),
    .point_y_i      (point_y_i),
    .rect_x_i       (rect_x_i),
    .rect_y_i       (rect_y_i),
    .rect_width_i   (rect_width_i),
    .rect_height_i  (rect_height_i),
    .priority_req_i (priority_req_i),
    .named_i        (named_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .hit_o          (hit_o),
    .region_index_o (region_index_o),
    .hit_priority_o (hit_priority_o)
  );

  // local copy of the region table and the configuration registers
  logic [11:0]        tbl_x    [SLOTS];
  logic [11:0]        tbl_y    [SLOTS];
  logic [12:0]        tbl_w    [SLOTS];
  logic [12:0]        tbl_h    [SLOTS];
  logic signed [15:0] tbl_rank [SLOTS];
  bit                 tbl_named[SLOTS];
  bit                 cfg_layer;
  logic [4:0]         cfg_count;
  logic [12:0]        cfg_map_w;
  logic [12:0]        cfg_map_h;

  hit_result_t pending_hits[$];   // answers still owed by the block
  int          failures    = 0;
  int          cycle_count = 0;
  int          burst_left  = 0;
  bit          hold_req    = 1'b0;

  // clock, 4 ns period
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // watchdog: a hung handshake or a lost result ends here
  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("*** FAILED ***");
    $finish;
  end

  task automatic note_failure(input string what, input hit_result_t want);
    failures++;
    if (failures <= MAX_REPORTS) begin
      $display("%s at cycle %0d: expected %0b/%0d/%0d, got %0b/%0d/%0d (hit/index/priority)",
               what, cycle_count, want.hit, want.idx, want.pri,
               hit_o, region_index_o, hit_priority_o);
    end
  endtask

  // scoring of one query point against the local table
  // half-open rectangles, later index wins on equal priority
  function automatic hit_result_t top_region_at(input logic signed [12:0] px,
                                                input logic signed [12:0] py);
    hit_result_t best;
    int          x;
    int          y;
    int          lim;
    best = '{hit: 1'b0, idx: 4'd0, pri: 16'sd0};
    x    = px;
    y    = py;
    lim  = (cfg_count > SLOTS) ? SLOTS : int'(cfg_count);
    // disabled layer, negative point or point off the map: straight miss
    if (cfg_layer && x >= 0 && y >= 0 && x < int'(cfg_map_w) && y < int'(cfg_map_h)) begin
      for (int i = 0; i < lim; i++) begin
        // zero extent or no name makes the entry invisible
        if (tbl_w[i] != 0 && tbl_h[i] != 0 && tbl_named[i] &&
            x >= int'(tbl_x[i]) && x < int'(tbl_x[i]) + int'(tbl_w[i]) &&
            y >= int'(tbl_y[i]) && y < int'(tbl_y[i]) + int'(tbl_h[i])) begin
          if (!best.hit || tbl_rank[i] >= best.pri) begin
            best.hit = 1'b1;
            best.idx = 4'(i);
            best.pri = tbl_rank[i];
          end
        end
      end
    end
    return best;
  endfunction

  // bookkeeping at the edge that accepts an item transfer
  task automatic take_transfer(input stim_t s);
    hit_result_t want;
    if (s.cmd == prht_pkg::CMD_WRITE) begin
      tbl_x[s.slot]     = s.rx;
      tbl_y[s.slot]     = s.ry;
      tbl_w[s.slot]     = s.rw;
      tbl_h[s.slot]     = s.rh;
      tbl_rank[s.slot]  = s.pri;
      tbl_named[s.slot] = s.nm;
    end else begin
      if (s.typed) begin
        want = '{hit: s.t_hit, idx: s.t_idx, pri: s.t_pri};
      end else begin
        want = top_region_at(s.px, s.py);
      end
      pending_hits.push_back(want);
    end
  endtask

  // item builders
  function automatic stim_t wr(input int slot, input int rx, input int ry, input int rw,
                               input int rh, input int pri, input int nm);
    stim_t s;
    s.cmd   = prht_pkg::CMD_WRITE;
    s.slot  = 4'(slot);
    s.px    = 13'($urandom);
    s.py    = 13'($urandom);
    s.rx    = 12'(rx);
    s.ry    = 12'(ry);
    s.rw    = 13'(rw);
    s.rh    = 13'(rh);
    s.pri   = 16'(pri);
    s.nm    = 1'(nm);
    s.typed = 1'b0;
    s.t_hit = 1'b0;
    s.t_idx = '0;
    s.t_pri = '0;
    return s;
  endfunction

  function automatic stim_t qy(input int px, input int py);
    stim_t s;
    s     = wr($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    s.cmd = prht_pkg::CMD_QUERY;
    s.px  = 13'(px);
    s.py  = 13'(py);
    return s;
  endfunction

  // query with its answer typed in
  function automatic stim_t qt(input int px, input int py, input int hit, input int idx,
                               input int pri);
    stim_t s;
    s       = qy(px, py);
    s.typed = 1'b1;
    s.t_hit = 1'(hit);
    s.t_idx = 4'(idx);
    s.t_pri = 16'(pri);
    return s;
  endfunction

  // mostly small rectangles near the origin with a few priorities, so
  // overlaps and ties are common; one in eight is full-range noise
  function automatic stim_t random_item();
    int pri;
    if ($urandom_range(0, 2) == 0) begin
      if ($urandom_range(0, 7) == 0) begin
        return wr($urandom_range(0, 15), $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom);
      end
      case ($urandom_range(0, 7))
        0:       pri = -32768;
        1:       pri = 32767;
        2:       pri = $urandom;
        default: pri = int'($urandom_range(0, 4)) - 2;
      endcase
      return wr($urandom_range(0, 15), $urandom_range(0, 60), $urandom_range(0, 60),
                ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 24),
                ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 24),
                pri, int'($urandom_range(0, 7) != 0));
    end
    if ($urandom_range(0, 7) == 0) begin
      return qy($urandom, $urandom);
    end
    return qy($urandom_range(0, 90), $urandom_range(0, 90));
  endfunction

  // one item transfer, driven at the falling edge and held until accepted
  task automatic send(input stim_t s);
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    command_i      <= s.cmd;
    entry_index_i  <= s.slot;
    point_x_i      <= s.px;
    point_y_i      <= s.py;
    rect_x_i       <= s.rx;
    rect_y_i       <= s.ry;
    rect_width_i   <= s.rw;
    rect_height_i  <= s.rh;
    priority_req_i <= s.pri;
    named_i        <= s.nm;
    do @(posedge clk_i); while (in_stall_o);
    take_transfer(s);
  endtask

  // bursts of random length with random gaps in between
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90)
                                               : $urandom_range(1, 16);
    end
    burst_left--;
  endtask

  // stop offering and wait for every owed answer
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk_i);
  endtask

  // apb write: setup cycle then access cycle, register taken when pready is high
  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      prht_pkg::REG_LAYER_ENABLED: cfg_layer = val[0];
      prht_pkg::REG_REGION_COUNT:  cfg_count = val[4:0];
      prht_pkg::REG_MAP_WIDTH:     cfg_map_w = val[12:0];
      prht_pkg::REG_MAP_HEIGHT:    cfg_map_h = val[12:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // new register setting, only once the block has gone quiet
  task automatic reconfigure(input int layer, input int count, input int mw, input int mh);
    drain();
    repeat (SETTLE) @(posedge clk_i);
    cfg_write(prht_pkg::REG_LAYER_ENABLED, 32'(layer));
    cfg_write(prht_pkg::REG_REGION_COUNT, 32'(count));
    cfg_write(prht_pkg::REG_MAP_WIDTH, 32'(mw));
    cfg_write(prht_pkg::REG_MAP_HEIGHT, 32'(mh));
  endtask

  // result side: stall pattern in segments, plus one long hold-off on request
  initial begin
    int mode;
    int seg_left;
    int hold_left;
    bit hold_done;
    seg_left  = 0;
    hold_left = 0;
    hold_done = 1'b0;
    mode      = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          mode     = $urandom_range(0, 3);
          seg_left = $urandom_range(8, 60);
        end
        seg_left--;
        case (mode)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 3) == 0);
          2:       out_stall_i <= ($urandom_range(0, 3) != 0);
          default: out_stall_i <= cycle_count[0];
        endcase
      end
    end
  end

  // result checking against the oldest owed answer
  always @(posedge clk_i) begin : check_results
    hit_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_hits.size() == 0) begin
        want = '{hit: 1'bx, idx: 'x, pri: 'x};
        note_failure("result with nothing owed", want);
      end else begin
        want = pending_hits.pop_front();
        if (hit_o !== want.hit || region_index_o !== want.idx ||
            hit_priority_o !== want.pri) begin
          note_failure("mismatch", want);
        end
      end
    end
  end

  // register settings for the random phases, extremes included
  int ph_layer[PHASES] = '{1, 1, 0, 1, 1, 1, 1, 1, 1};
  int ph_count[PHASES] = '{16, 31, 16, 9, 0, 1, 16, 16, 12};
  int ph_mw   [PHASES] = '{4096, 8191, 4096, 50, 4096, 4096, 0, 64, 4096};
  int ph_mh   [PHASES] = '{4096, 8191, 4096, 30, 4096, 4096, 0, 64, 40};

  initial begin
    stim_t directed[$];
    // everything known from time zero, reset held at the start
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid_i     = 1'b0;
    command_i      = prht_pkg::CMD_WRITE;
    entry_index_i  = '0;
    point_x_i      = '0;
    point_y_i      = '0;
    rect_x_i       = '0;
    rect_y_i       = '0;
    rect_width_i   = '0;
    rect_height_i  = '0;
    priority_req_i = '0;
    named_i        = 1'b0;
    out_stall_i    = 1'b0;
    cfg_layer      = 1'b0;
    cfg_count      = '0;
    cfg_map_w      = '0;
    cfg_map_h      = '0;
    for (int i = 0; i < SLOTS; i++) begin
      tbl_named[i] = 1'b0;
      tbl_x[i]     = '0;
      tbl_y[i]     = '0;
      tbl_w[i]     = '0;
      tbl_h[i]     = '0;
      tbl_rank[i]  = '0;
    end
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // registers come out of reset cleared: the layer is off, so a miss
    send(qt(10, 10, 0, 0, 0));

    // fill every slot, unnamed, so no scan ever reads a slot never written
    for (int i = 0; i < SLOTS; i++) begin
      send(wr(i, $urandom, $urandom, $urandom, $urandom, $urandom, 0));
    end
    reconfigure(1, 16, 4096, 4096);

    // directed part
    // slot 0 covers the whole map at the lowest priority
    directed.push_back(wr(0, 0, 0, 4096, 4096, -32768, 1));
    directed.push_back(qt(0, 0, 1, 0, -32768));
    directed.push_back(qt(4095, 4095, 1, 0, -32768));
    // negative coordinates lie off the map
    directed.push_back(qt(-1, 0, 0, 0, 0));
    directed.push_back(qt(0, -4096, 0, 0, 0));
    // single cell at top priority, half-open edges
    directed.push_back(wr(15, 100, 200, 1, 1, 32767, 1));
    directed.push_back(qt(100, 200, 1, 15, 32767));
    directed.push_back(qt(101, 200, 1, 0, -32768));
    directed.push_back(qt(100, 201, 1, 0, -32768));
    // equal priority: the later slot wins where they overlap
    directed.push_back(wr(5, 100, 200, 10, 10, 32767, 1));
    directed.push_back(qt(100, 200, 1, 15, 32767));
    directed.push_back(qt(109, 209, 1, 5, 32767));
    // unnamed, zero width and zero height entries stay invisible
    directed.push_back(wr(7, 4095, 4095, 8191, 8191, 1, 0));
    directed.push_back(qy(4095, 4095));
    directed.push_back(wr(7, 4095, 4095, 0, 8191, 1, 1));
    directed.push_back(qy(4095, 4095));
    directed.push_back(wr(7, 4095, 4095, 8191, 0, 1, 1));
    directed.push_back(qy(4095, 4095));
    directed.push_back(wr(7, 4095, 4095, 8191, 8191, 1, 1));
    directed.push_back(qy(4095, 4095));
    // dropping the name of the fallback region
    directed.push_back(wr(0, 0, 0, 4096, 4096, -32768, 0));
    directed.push_back(qy(0, 0));
    directed.push_back(qt(-4096, -4096, 0, 0, 0));
    foreach (directed[i]) begin
      pace();
      send(directed[i]);
    end

    // random phases, one register setting each
    for (int p = 0; p < PHASES; p++) begin
      reconfigure(ph_layer[p], ph_count[p], ph_mw[p], ph_mh[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // long result hold-off while items keep coming
        if (p == 1 && n == 10) hold_req = 1'b1;
        // sender waits for every owed answer before going on
        if (p == 3 && n == 40) drain();
        pace();
        send(random_item());
      end
    end

    drain();
    repeat (SETTLE) @(posedge clk_i);
    if (failures == 0 && pending_hits.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* priority_rectangle_hit_test.f */
rtl/prht_pkg.sv
rtl/priority_rectangle_hit_test.sv
dv/tb_priority_rectangle_hit_test.sv
